// ===== rtl/ght_pkg.sv =====
// ----------------------------------------------------------------------------
// ght_pkg
// shared types, codes and helpers of the generational handle table
// ----------------------------------------------------------------------------
`default_nettype none

package ght_pkg;

    localparam int SLOTS_DEF = 256;

    localparam int HND_W  = 32;
    localparam int IDX_W  = 16;
    localparam int SER_W  = 16;
    localparam int DATA_W = 32;
    localparam int CFG_W  = 9;
    localparam int LIM_W  = IDX_W + 1;
    localparam int REQ_W  = 3;
    localparam int STS_W  = 2;

    // occupancy bitmap word
    localparam int OCC_W  = 32;
    localparam int OCC_SH = 5;

    localparam logic [CFG_W-1:0] ACTIVE_RESET = 9'd256;

    localparam logic [REQ_W-1:0] REQ_ALLOC  = 3'd0;
    localparam logic [REQ_W-1:0] REQ_LOOKUP = 3'd1;
    localparam logic [REQ_W-1:0] REQ_ADDREF = 3'd2;
    localparam logic [REQ_W-1:0] REQ_DECREF = 3'd3;
    localparam logic [REQ_W-1:0] REQ_SWAP   = 3'd4;
    localparam logic [REQ_W-1:0] REQ_DELETE = 3'd5;

    localparam logic [STS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STS_W-1:0] ST_INVALID = 2'd1;
    localparam logic [STS_W-1:0] ST_FULL    = 2'd2;
    localparam logic [STS_W-1:0] ST_ZERO    = 2'd3;

    typedef struct packed {
        logic [SER_W-1:0]  serial;
        logic [DATA_W-1:0] refs;
        logic [DATA_W-1:0] size;
        logic [DATA_W-1:0] payload;
    } t_slot;

    typedef struct packed {
        logic [STS_W-1:0]  status;
        logic [HND_W-1:0]  handle;
        logic              occ;
        logic [DATA_W-1:0] payload;
        logic [DATA_W-1:0] size;
        logic [DATA_W-1:0] refs;
        logic [CFG_W-1:0]  used;
    } t_result;

    // serial advance, zero is never handed out
    function automatic logic [SER_W-1:0] next_serial(input logic [SER_W-1:0] s);
        logic [SER_W-1:0] t;
        t = s + 1'b1;
        return (t == '0) ? SER_W'(1) : t;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/ght_slot_store.sv =====
// ----------------------------------------------------------------------------
// ght_slot_store
// per-slot record memory: serial, reference count, size and payload word
// ----------------------------------------------------------------------------
`default_nettype none

module ght_slot_store
    import ght_pkg::*;
#(
    parameter int DEPTH = SLOTS_DEF,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_rd_en,
    input  wire logic [AW-1:0] i_rd_addr,
    output t_slot              o_rd_data,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire t_slot         i_wr_data
);

    t_slot r_mem [DEPTH];
    t_slot r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== rtl/ght_occ_map.sv =====
// ----------------------------------------------------------------------------
// ght_occ_map
// occupancy bitmap memory, one bit per slot, with a lowest-free-bit finder
// on the registered read word
// ----------------------------------------------------------------------------
`default_nettype none

module ght_occ_map
    import ght_pkg::*;
#(
    parameter int WORDS = (SLOTS_DEF + OCC_W - 1) / OCC_W,
    localparam int WA   = (WORDS > 1) ? $clog2(WORDS) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_rd_en,
    input  wire logic [WA-1:0]     i_rd_addr,
    output logic [OCC_W-1:0]       o_rd_bits,
    output logic                   o_free_any,
    output logic [OCC_SH-1:0]      o_free_bit,
    input  wire logic              i_we,
    input  wire logic [WA-1:0]     i_wr_addr,
    input  wire logic [OCC_W-1:0]  i_wr_bits
);

    logic [OCC_W-1:0] r_mem [WORDS];
    logic [OCC_W-1:0] r_rd_bits;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_bits;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_bits <= r_mem[i_rd_addr];
        end
    end

    // priority encode the lowest clear bit
    always_comb begin
        o_free_bit = '0;
        for (int b = OCC_W - 1; b >= 0; b--) begin
            if (!r_rd_bits[b]) begin
                o_free_bit = OCC_SH'(b);
            end
        end
    end

    assign o_free_any = ~&r_rd_bits;
    assign o_rd_bits  = r_rd_bits;

endmodule

`default_nettype wire

// ===== rtl/generational_handle_table.sv =====
// ----------------------------------------------------------------------------
// generational_handle_table
// slot table that hands out 32-bit handles (index in bits 31..16, nonzero
// serial in bits 15..0) with allocate, lookup, reference counting, swap
// and delete
// ----------------------------------------------------------------------------
`default_nettype none

// One request is handled at a time and gives exactly one result. All slot
// state sits in two single-port-style memories with registered reads: a
// record memory (serial, count, size, payload) and an occupancy bitmap of
// 32 slots per word. After reset the block sweeps both memories and holds
// o_stall high meanwhile; the active_slots register can be written during
// the sweep. Zero-size allocate, swap of identical handles and unknown
// codes go straight to the staged result; lookup, add ref, dec ref and
// delete do one record read, then a read-modify-write, and any invalid first
// handle is reported after that read; swap reads both records and writes
// both back, stopping after the second read when the second handle is
// invalid; allocate scans the bitmap for a free bit, then reads and updates
// that slot's record, or reports a full table from the scan, skipping each
// completely occupied bitmap word, at most ceil(active/32) words.
// The scan starts at a hint word below which every slot is known to be
// taken, so steady allocate/delete traffic usually finds its slot in the
// first word. A new transaction is accepted in the cycle its predecessor's
// result moves into the output register, and a finished result waiting on
// i_stall does not block the next transaction from being worked on.

module generational_handle_table
    import ght_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,

    // configuration
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_W-1:0]     i_cfg_data,

    // request channel
    input  wire logic                 i_valid,
    output logic                      o_stall,
    input  wire logic [REQ_W-1:0]     i_req_type,
    input  wire logic [HND_W-1:0]     i_handle,
    input  wire logic [HND_W-1:0]     i_second_handle,
    input  wire logic [DATA_W-1:0]    i_alloc_size,
    input  wire logic [DATA_W-1:0]    i_entry_word,

    // result channel
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output logic [STS_W-1:0]          o_status,
    output logic [HND_W-1:0]          o_handle_out,
    output logic                      o_occupied,
    output logic [DATA_W-1:0]         o_payload_out,
    output logic [DATA_W-1:0]         o_size_out,
    output logic signed [DATA_W-1:0]  o_ref_count_out,
    output logic [CFG_W-1:0]          o_used_count
);

    localparam int AW       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int NWORDS   = (SLOTS + OCC_W - 1) / OCC_W;
    localparam int WA       = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int USED_MAX = (SLOTS < 256) ? SLOTS : 256;

    // sequencer states
    localparam logic [2:0] S_CLEAR = 3'd0;  // reset sweep of both memories
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_RD1   = 3'd2;  // first handle's record on the read port
    localparam logic [2:0] S_RD2   = 3'd3;  // swap: second handle's record
    localparam logic [2:0] S_SWB   = 3'd4;  // swap: write back the first slot
    localparam logic [2:0] S_SCAN  = 3'd5;  // allocate: bitmap word on the read port
    localparam logic [2:0] S_ALOC  = 3'd6;  // allocate: chosen slot's record
    localparam logic [2:0] S_DONE  = 3'd7;  // result staged for the output register

    // control registers
    logic [2:0]         r_state, n_state;
    logic [AW-1:0]      r_clr, n_clr;
    logic [CFG_W-1:0]   r_active, n_active;
    logic [CFG_W-1:0]   r_used, n_used;
    logic [WA-1:0]      r_base, n_base;
    logic               r_out_valid, n_out_valid;

    // transaction and working registers
    logic [REQ_W-1:0]   r_req, n_req;
    logic [HND_W-1:0]   r_h, n_h;
    logic [HND_W-1:0]   r_h2, n_h2;
    logic [DATA_W-1:0]  r_size, n_size;
    logic [DATA_W-1:0]  r_word, n_word;
    logic [WA-1:0]      r_ptr, n_ptr;
    logic [IDX_W-1:0]   r_fidx, n_fidx;
    t_slot              r_a, n_a;
    logic               r_a_occ, n_a_occ;
    logic [OCC_W-1:0]   r_a_bits, n_a_bits;
    t_result            r_res, n_res;
    t_result            r_out, n_out;

    // memory ports
    logic               w_s_rd_en;
    logic [AW-1:0]      w_s_rd_addr;
    t_slot              w_s_rd_data;
    logic               w_s_we;
    logic [AW-1:0]      w_s_wr_addr;
    t_slot              w_s_wr_data;

    logic               w_m_rd_en;
    logic [WA-1:0]      w_m_rd_addr;
    logic [OCC_W-1:0]   w_m_rd_bits;
    logic               w_m_free_any;
    logic [OCC_SH-1:0]  w_m_free_bit;
    logic               w_m_we;
    logic [WA-1:0]      w_m_wr_addr;
    logic [OCC_W-1:0]   w_m_wr_bits;

    // decoded handles and checks
    logic               w_out_free;
    logic               w_can_take;
    logic               w_accept;
    logic [IDX_W-1:0]   w_in_idx;
    logic [IDX_W-1:0]   w_a_idx;
    logic [IDX_W-1:0]   w_b_idx;
    logic [OCC_SH-1:0]  w_a_bit;
    logic [OCC_SH-1:0]  w_b_bit;
    logic [WA-1:0]      w_a_wd;
    logic [WA-1:0]      w_b_wd;
    logic [LIM_W-1:0]   w_lim;
    logic               w_a_ok;
    logic               w_b_ok;
    logic               w_a_occ_now;
    logic               w_b_occ_now;
    logic [IDX_W-1:0]   w_found;
    logic [DATA_W-1:0]  w_refs_new;
    logic [OCC_W-1:0]   w_bits_b;
    logic [WA-1:0]      w_free_wd;

    ght_slot_store #(
        .DEPTH (SLOTS)
    ) u_slots (
        .i_clk     (i_clk),
        .i_rd_en   (w_s_rd_en),
        .i_rd_addr (w_s_rd_addr),
        .o_rd_data (w_s_rd_data),
        .i_we      (w_s_we),
        .i_wr_addr (w_s_wr_addr),
        .i_wr_data (w_s_wr_data)
    );

    ght_occ_map #(
        .WORDS (NWORDS)
    ) u_occ (
        .i_clk      (i_clk),
        .i_rd_en    (w_m_rd_en),
        .i_rd_addr  (w_m_rd_addr),
        .o_rd_bits  (w_m_rd_bits),
        .o_free_any (w_m_free_any),
        .o_free_bit (w_m_free_bit),
        .i_we       (w_m_we),
        .i_wr_addr  (w_m_wr_addr),
        .i_wr_bits  (w_m_wr_bits)
    );

    // output register frees up when empty or taken this cycle
    assign w_out_free = !r_out_valid || !i_stall;
    assign w_can_take = (r_state == S_IDLE) || ((r_state == S_DONE) && w_out_free);
    assign w_accept   = i_valid && w_can_take;
    assign o_stall    = !w_can_take;

    // active limit is min(active_slots, SLOTS)
    assign w_lim = (LIM_W'(r_active) < LIM_W'(SLOTS)) ? LIM_W'(r_active) : LIM_W'(SLOTS);

    assign w_in_idx = i_handle[HND_W-1:SER_W];
    assign w_a_idx  = r_h[HND_W-1:SER_W];
    assign w_b_idx  = r_h2[HND_W-1:SER_W];
    assign w_a_bit  = w_a_idx[OCC_SH-1:0];
    assign w_b_bit  = w_b_idx[OCC_SH-1:0];
    assign w_a_wd   = WA'(w_a_idx >> OCC_SH);
    assign w_b_wd   = WA'(w_b_idx >> OCC_SH);

    // handle check against the record on the read port
    assign w_a_ok = (r_h != '0) && (LIM_W'(w_a_idx) < w_lim)
                    && (w_s_rd_data.serial == r_h[SER_W-1:0]);
    assign w_b_ok = (r_h2 != '0) && (LIM_W'(w_b_idx) < w_lim)
                    && (w_s_rd_data.serial == r_h2[SER_W-1:0]);

    assign w_a_occ_now = w_m_rd_bits[w_a_bit];
    assign w_b_occ_now = w_m_rd_bits[w_b_bit];
    assign w_found     = IDX_W'({r_ptr, w_m_free_bit});

    assign w_refs_new = (r_req == REQ_ADDREF) ? (w_s_rd_data.refs + 1'b1)
                                              : (w_s_rd_data.refs - 1'b1);

    // word of the slot that a swap leaves free (only used when occupancy differs)
    assign w_free_wd = r_a_occ ? w_a_wd : w_b_wd;

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_active    = r_active;
        n_used      = r_used;
        n_base      = r_base;
        n_out_valid = r_out_valid;
        n_req       = r_req;
        n_h         = r_h;
        n_h2        = r_h2;
        n_size      = r_size;
        n_word      = r_word;
        n_ptr       = r_ptr;
        n_fidx      = r_fidx;
        n_a         = r_a;
        n_a_occ     = r_a_occ;
        n_a_bits    = r_a_bits;
        n_res       = r_res;
        n_out       = r_out;

        w_s_rd_en   = 1'b0;
        w_s_rd_addr = '0;
        w_s_we      = 1'b0;
        w_s_wr_addr = '0;
        w_s_wr_data = '0;
        w_m_rd_en   = 1'b0;
        w_m_rd_addr = '0;
        w_m_we      = 1'b0;
        w_m_wr_addr = '0;
        w_m_wr_bits = '0;

        // swap: second slot's word with both exchanged bits where they share it
        w_bits_b = w_m_rd_bits;
        w_bits_b[w_b_bit] = r_a_occ;
        if (w_b_wd == w_a_wd) begin
            w_bits_b[w_a_bit] = w_b_occ_now;
        end

        if (i_cfg_we) begin
            n_active = i_cfg_data;
        end

        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_CLEAR: begin
                // one record and at most one bitmap word per cycle
                w_s_we      = 1'b1;
                w_s_wr_addr = r_clr;
                w_s_wr_data = '{serial: SER_W'(1), refs: '0, size: '0, payload: '0};
                if (LIM_W'(r_clr) < LIM_W'(NWORDS)) begin
                    w_m_we      = 1'b1;
                    w_m_wr_addr = WA'(r_clr);
                    w_m_wr_bits = '0;
                end
                n_clr = r_clr + 1'b1;
                if (r_clr == AW'(SLOTS - 1)) begin
                    n_state = S_IDLE;
                end
            end

            S_IDLE: begin
                n_state = S_IDLE;
            end

            S_RD1: begin
                n_state = S_DONE;
                if (r_req == REQ_SWAP) begin
                    if (!w_a_ok) begin
                        n_res.status = ST_INVALID;
                    end else begin
                        // keep the first slot, fetch the second
                        n_a         = w_s_rd_data;
                        n_a_occ     = w_a_occ_now;
                        n_a_bits    = w_m_rd_bits;
                        w_s_rd_en   = 1'b1;
                        w_s_rd_addr = w_b_idx[AW-1:0];
                        w_m_rd_en   = 1'b1;
                        w_m_rd_addr = w_b_wd;
                        n_state     = S_RD2;
                    end
                end else if (!w_a_ok) begin
                    n_res.status = ST_INVALID;
                    // only the count operations report all ones on a bad handle
                    if ((r_req == REQ_ADDREF) || (r_req == REQ_DECREF)) begin
                        n_res.refs = '1;
                    end
                end else begin
                    n_res.status  = ST_OK;
                    n_res.occ     = w_a_occ_now;
                    n_res.payload = w_a_occ_now ? w_s_rd_data.payload : '0;
                    n_res.size    = w_s_rd_data.size;
                    n_res.refs    = w_s_rd_data.refs;
                    unique case (r_req)
                        REQ_ADDREF, REQ_DECREF: begin
                            w_s_we      = 1'b1;
                            w_s_wr_addr = w_a_idx[AW-1:0];
                            w_s_wr_data = w_s_rd_data;
                            w_s_wr_data.refs = w_refs_new;
                            n_res.refs  = w_refs_new;
                        end
                        REQ_DELETE: begin
                            w_s_we      = 1'b1;
                            w_s_wr_addr = w_a_idx[AW-1:0];
                            w_s_wr_data = '{serial:  next_serial(w_s_rd_data.serial),
                                            refs: '0, size: '0, payload: '0};
                            w_m_we      = 1'b1;
                            w_m_wr_addr = w_a_wd;
                            w_m_wr_bits = w_m_rd_bits & ~(OCC_W'(1) << w_a_bit);
                            if (w_a_occ_now) begin
                                n_used = r_used - 1'b1;
                                if (w_a_wd < r_base) begin
                                    n_base = w_a_wd;
                                end
                            end
                            n_res.occ     = 1'b0;
                            n_res.payload = '0;
                            n_res.size    = '0;
                            n_res.refs    = '0;
                            n_res.used    = w_a_occ_now ? (r_used - 1'b1) : r_used;
                        end
                        default: begin
                            // lookup reports the slot as is
                        end
                    endcase
                end
            end

            S_RD2: begin
                if (!w_b_ok) begin
                    n_res.status = ST_INVALID;
                    n_state      = S_DONE;
                end else begin
                    // second slot takes the first slot's size and payload now
                    w_s_we      = 1'b1;
                    w_s_wr_addr = w_b_idx[AW-1:0];
                    w_s_wr_data = '{serial:  w_s_rd_data.serial, refs: w_s_rd_data.refs,
                                    size:    r_a.size, payload: r_a.payload};
                    w_m_we      = 1'b1;
                    w_m_wr_addr = w_b_wd;
                    w_m_wr_bits = w_bits_b;
                    // first slot's new contents wait in r_a for the next cycle
                    n_a.size    = w_s_rd_data.size;
                    n_a.payload = w_s_rd_data.payload;
                    n_a_occ     = w_b_occ_now;
                    n_a_bits[w_a_bit] = w_b_occ_now;
                    if ((r_a_occ != w_b_occ_now) && (w_free_wd < r_base)) begin
                        n_base = w_free_wd;
                    end
                    n_res.status = ST_OK;
                    n_state      = S_SWB;
                end
            end

            S_SWB: begin
                w_s_we      = 1'b1;
                w_s_wr_addr = w_a_idx[AW-1:0];
                w_s_wr_data = r_a;
                // a shared word was already written whole
                if (w_a_wd != w_b_wd) begin
                    w_m_we      = 1'b1;
                    w_m_wr_addr = w_a_wd;
                    w_m_wr_bits = r_a_bits;
                end
                n_state = S_DONE;
            end

            S_SCAN: begin
                if (LIM_W'({r_ptr, {OCC_SH{1'b0}}}) >= w_lim) begin
                    n_res.status = ST_FULL;
                    n_state      = S_DONE;
                end else if (w_m_free_any) begin
                    if (LIM_W'(w_found) >= w_lim) begin
                        n_res.status = ST_FULL;
                        n_state      = S_DONE;
                    end else begin
                        w_m_we      = 1'b1;
                        w_m_wr_addr = r_ptr;
                        w_m_wr_bits = w_m_rd_bits | (OCC_W'(1) << w_m_free_bit);
                        n_base      = r_ptr;
                        n_fidx      = w_found;
                        w_s_rd_en   = 1'b1;
                        w_s_rd_addr = w_found[AW-1:0];
                        n_state     = S_ALOC;
                    end
                end else if (r_ptr == WA'(NWORDS - 1)) begin
                    n_res.status = ST_FULL;
                    n_state      = S_DONE;
                end else begin
                    // word fully taken, move on
                    n_ptr       = r_ptr + 1'b1;
                    w_m_rd_en   = 1'b1;
                    w_m_rd_addr = r_ptr + 1'b1;
                end
            end

            S_ALOC: begin
                w_s_we      = 1'b1;
                w_s_wr_addr = r_fidx[AW-1:0];
                w_s_wr_data = '{serial:  w_s_rd_data.serial, refs: w_s_rd_data.refs,
                                size:    r_size, payload: r_word};
                n_used        = r_used + 1'b1;
                n_res.status  = ST_OK;
                n_res.handle  = {r_fidx, w_s_rd_data.serial};
                n_res.occ     = 1'b1;
                n_res.payload = r_word;
                n_res.size    = r_size;
                n_res.refs    = w_s_rd_data.refs;
                n_res.used    = r_used + 1'b1;
                n_state       = S_DONE;
            end

            S_DONE: begin
                if (w_out_free) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
        endcase

        // start of a transaction: capture and issue the first reads
        if (w_accept) begin
            n_req       = i_req_type;
            n_h         = i_handle;
            n_h2        = i_second_handle;
            n_size      = i_alloc_size;
            n_word      = i_entry_word;
            n_res       = '0;
            n_res.used  = r_used;
            w_s_rd_en   = 1'b1;
            w_s_rd_addr = w_in_idx[AW-1:0];
            w_m_rd_en   = 1'b1;
            w_m_rd_addr = WA'(w_in_idx >> OCC_SH);
            unique case (i_req_type)
                REQ_ALLOC: begin
                    if (i_alloc_size == '0) begin
                        n_res.status = ST_ZERO;
                        n_state      = S_DONE;
                    end else begin
                        w_m_rd_addr = r_base;
                        n_ptr       = r_base;
                        n_state     = S_SCAN;
                    end
                end
                REQ_LOOKUP, REQ_ADDREF, REQ_DECREF, REQ_DELETE: begin
                    n_state = S_RD1;
                end
                REQ_SWAP: begin
                    if (i_handle == i_second_handle) begin
                        n_res.status = ST_OK;
                        n_state      = S_DONE;
                    end else begin
                        n_state = S_RD1;
                    end
                end
                default: begin
                    n_res.status = ST_INVALID;
                    n_state      = S_DONE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_active    <= ACTIVE_RESET;
            r_used      <= '0;
            r_base      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_active    <= n_active;
            r_used      <= n_used;
            r_base      <= n_base;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req    <= n_req;
        r_h      <= n_h;
        r_h2     <= n_h2;
        r_size   <= n_size;
        r_word   <= n_word;
        r_ptr    <= n_ptr;
        r_fidx   <= n_fidx;
        r_a      <= n_a;
        r_a_occ  <= n_a_occ;
        r_a_bits <= n_a_bits;
        r_res    <= n_res;
        r_out    <= n_out;
    end

    assign o_valid         = r_out_valid;
    assign o_status        = r_out.status;
    assign o_handle_out    = r_out.handle;
    assign o_occupied      = r_out.occ;
    assign o_payload_out   = r_out.payload;
    assign o_size_out      = r_out.size;
    assign o_ref_count_out = $signed(r_out.refs);
    assign o_used_count    = r_out.used;

`ifndef SYNTHESIS
    // no transaction may slip in while the memories are being swept
    a_no_take_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> o_stall)
        else $error("request channel open during memory sweep");

    // a granted handle never carries serial zero
    a_alloc_serial: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ALOC) |=> (r_res.handle[SER_W-1:0] != '0))
        else $error("allocate granted a zero serial");

    // a staged result reaches the output register as soon as it is free
    a_done_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DONE) && w_out_free) |=> o_valid)
        else $error("staged result not presented");

    // occupied count cannot exceed the usable slots
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CFG_W'(USED_MAX))
        else $error("used count out of range");
`endif

endmodule

`default_nettype wire
